@@ rtl/core/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Types, constants and step functions shared by the momentum-to-velocity
// pipeline.
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int VEL_DIMS_DEF = 3;
    localparam logic [30:0] LIGHT_SPEED_RST = 31'd65536;

    localparam int N_W       = 128;        // radicand width
    localparam int ROOT_W    = 64;         // square root width
    localparam int SQ_REM_W  = ROOT_W + 2;
    localparam int SQ_STEPS  = 2;          // root bits per sqrt stage
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

    localparam int CP_W      = 63;         // light speed times momentum magnitude
    localparam int DV_Q_W    = 32;
    localparam int DV_STEPS  = 2;          // quotient bits per divide stage
    localparam int DV_STAGES = DV_Q_W / DV_STEPS;

    typedef struct packed {
        logic signed [31:0] momentum_x;
        logic signed [31:0] momentum_y;
        logic signed [31:0] momentum_z;
        logic [30:0]        rest_mass;
        logic               particle_active;
    } t_in;

    typedef struct packed {
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
    } t_out;

    // Data that rides along the square root pipeline.
    typedef struct packed {
        logic [2:0][CP_W-1:0] cp;
        logic [2:0]           neg;
        logic                 active;
    } t_side;

    // Data that rides along the divide pipeline.
    typedef struct packed {
        logic [2:0] neg;
        logic       active;
        logic       den_zero;
    } t_dv_side;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [N_W-1:0]      n;
    } t_sq;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [DV_Q_W-1:0] q;
        logic [DV_Q_W-1:0] n;
    } t_dv;

    // One digit of the bitwise integer square root.
    function automatic t_sq sq_step(t_sq s);
        t_sq               r;
        logic [SQ_REM_W+1:0] acc;
        logic [SQ_REM_W+1:0] trial;
        acc   = {s.rem, s.n[N_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        if (acc >= trial) begin
            r.rem  = SQ_REM_W'(acc - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = acc[SQ_REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        r.n = {s.n[N_W-3:0], 2'b00};
        return r;
    endfunction

    // One bit of restoring division; the remainder stays below the divisor.
    function automatic t_dv dv_step(t_dv s, logic [ROOT_W-1:0] den);
        t_dv             r;
        logic [ROOT_W:0] acc;
        acc = {s.rem, s.n[DV_Q_W-1]};
        if (acc >= {1'b0, den}) begin
            r.rem = ROOT_W'(acc - {1'b0, den});
            r.q   = {s.q[DV_Q_W-2:0], 1'b1};
        end else begin
            r.rem = acc[ROOT_W-1:0];
            r.q   = {s.q[DV_Q_W-2:0], 1'b0};
        end
        r.n = {s.n[DV_Q_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

@@ rtl/core/relativistic_momentum_to_velocity.sv @@
// ----------------------------------------------------------------------------
// relativistic_momentum_to_velocity
// Converts particle momentum to velocity, v = c*p / sqrt((m*c)^2 + |p|^2),
// in Q16.16.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (light speed)
//
// One beat is accepted every cycle while the pipeline advances; each result
// passes through three product stages, 32 square root stages, 16 divide stages
// and the output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Reset clears the valid bits and sets light speed to 1.0.
// ----------------------------------------------------------------------------
module relativistic_momentum_to_velocity
    import rmv_pkg::*;
#(
    parameter int VEL_DIMS = VEL_DIMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    logic [30:0]       r_light_speed;
    logic              en;
    logic              fr_vld;
    logic [N_W-1:0]    fr_n;
    t_side             fr_side;
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_speed <= LIGHT_SPEED_RST;
        end else if (i_cfg_valid) begin
            r_light_speed <= i_cfg_data;
        end
    end

    rmv_front #(
        .VEL_DIMS (VEL_DIMS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (i_in_valid),
        .i_data        (i_in_data),
        .i_light_speed (r_light_speed),
        .o_vld         (fr_vld),
        .o_n           (fr_n),
        .o_side        (fr_side)
    );

    rmv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_n     (fr_n),
        .i_side  (fr_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    rmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_den   (sq_root),
        .i_side  (sq_side),
        .o_vld   (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

@@ rtl/core/rmv_front.sv @@
// ----------------------------------------------------------------------------
// rmv_front
// Three stages: magnitudes and products, partial products of (m*c)^2, and
// the 128-bit radicand.
// ----------------------------------------------------------------------------
module rmv_front
    import rmv_pkg::*;
#(
    parameter int VEL_DIMS = VEL_DIMS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  t_in            i_data,
    input  logic [30:0]    i_light_speed,
    output logic           o_vld,
    output logic [N_W-1:0] o_n,
    output t_side          o_side
);

    // Stage 1
    logic                  r1_vld;
    logic [2:0][63:0]      r1_sq, n1_sq;
    logic [61:0]           r1_mc;
    t_side                 r1_side, n1_side;
    // Stage 2
    logic                  r2_vld;
    logic [61:0]           r2_ll, r2_lh, r2_hh;
    logic [63:0]           r2_sumsq;
    t_side                 r2_side;
    // Stage 3
    logic                  r3_vld;
    logic [N_W-1:0]        r3_n, n3_n;
    t_side                 r3_side;

    logic [2:0][31:0]      raw;
    logic [2:0][31:0]      mag;

    always_comb begin
        raw[0] = i_data.momentum_x;
        raw[1] = i_data.momentum_y;
        raw[2] = (VEL_DIMS > 2) ? i_data.momentum_z : 32'd0;
        for (int i = 0; i < 3; i++) begin
            n1_side.neg[i] = raw[i][31];
            mag[i]         = raw[i][31] ? 32'd0 - raw[i] : raw[i];
            n1_sq[i]       = 64'(mag[i]) * 64'(mag[i]);
            n1_side.cp[i]  = CP_W'(63'(i_light_speed) * 63'(mag[i]));
        end
        n1_side.active = i_data.particle_active;
    end

    // (h*2^31 + l)^2 = hh*2^62 + lh*2^32 + ll
    always_comb begin
        n3_n = (N_W'(r2_hh) << 62) + (N_W'(r2_lh) << 32) + N_W'(r2_ll)
             + (N_W'(r2_sumsq) << 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq    <= n1_sq;
            r1_mc    <= 62'(i_data.rest_mass) * 62'(i_light_speed);
            r1_side  <= n1_side;
            r2_ll    <= 62'(r1_mc[30:0]) * 62'(r1_mc[30:0]);
            r2_lh    <= 62'(r1_mc[30:0]) * 62'(r1_mc[61:31]);
            r2_hh    <= 62'(r1_mc[61:31]) * 62'(r1_mc[61:31]);
            r2_sumsq <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_side  <= r1_side;
            r3_n     <= n3_n;
            r3_side  <= r2_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_n    = r3_n;
    assign o_side = r3_side;

endmodule

@@ rtl/core/rmv_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmv_sqrt
// Pipelined integer square root of the 128-bit radicand, two root bits per
// stage.
// ----------------------------------------------------------------------------
module rmv_sqrt
    import rmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [N_W-1:0]    i_n,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    t_sq                  r_sq   [SQ_STAGES];
    t_side                r_side [SQ_STAGES];
    logic                 r_vld  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        t_sq   st_in;
        t_sq   n_sq;
        t_side side_in;
        logic  vld_in;

        if (k == 0) begin : g_first
            assign st_in   = '{rem: '0, root: '0, n: i_n};
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_rest
            assign st_in   = r_sq[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        always_comb begin
            n_sq = st_in;
            for (int j = 0; j < SQ_STEPS; j++) begin
                n_sq = sq_step(n_sq);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k]   <= n_sq;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_sq[SQ_STAGES-1].root;
    assign o_side = r_side[SQ_STAGES-1];

endmodule

@@ rtl/core/rmv_div.sv @@
// ----------------------------------------------------------------------------
// rmv_div
// Three pipelined restoring dividers, two quotient bits per stage, and the
// signed result register.
// ----------------------------------------------------------------------------
module rmv_div
    import rmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [ROOT_W-1:0] i_den,
    input  t_side             i_side,
    output logic              o_vld,
    output t_out              o_data
);

    t_dv [2:0]            r_dv   [DV_STAGES];
    logic [ROOT_W-1:0]    r_den  [DV_STAGES];
    t_dv_side             r_side [DV_STAGES];
    logic                 r_vld  [DV_STAGES];
    logic                 r_out_vld;
    t_out                 r_out, n_out;

    for (genvar k = 0; k < DV_STAGES; k++) begin : g_stage
        t_dv [2:0]         st_in;
        t_dv [2:0]         n_dv;
        logic [ROOT_W-1:0] den_in;
        t_dv_side          side_in;
        logic              vld_in;

        if (k == 0) begin : g_first
            // The numerator is cp * 2^16; its top part starts as the remainder.
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    st_in[l].rem = ROOT_W'(i_side.cp[l][CP_W-1:16]);
                    st_in[l].q   = '0;
                    st_in[l].n   = {i_side.cp[l][15:0], 16'd0};
                end
                side_in.neg      = i_side.neg;
                side_in.active   = i_side.active;
                side_in.den_zero = (i_den == '0);
            end
            assign den_in = i_den;
            assign vld_in = i_vld;
        end else begin : g_rest
            assign st_in   = r_dv[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        always_comb begin
            n_dv = st_in;
            for (int l = 0; l < 3; l++) begin
                for (int j = 0; j < DV_STEPS; j++) begin
                    n_dv[l] = dv_step(n_dv[l], den_in);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k]   <= n_dv;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    logic [2:0][31:0] vel;
    logic [2:0][31:0] qmag;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qmag[l] = r_dv[DV_STAGES-1][l].q[31] ? 32'h7FFF_FFFF
                    : {1'b0, r_dv[DV_STAGES-1][l].q[30:0]};
            if (!r_side[DV_STAGES-1].active || r_side[DV_STAGES-1].den_zero) begin
                vel[l] = '0;
            end else if (r_side[DV_STAGES-1].neg[l]) begin
                vel[l] = 32'd0 - qmag[l];
            end else begin
                vel[l] = qmag[l];
            end
        end
        n_out.velocity_x = vel[0];
        n_out.velocity_y = vel[1];
        n_out.velocity_z = vel[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule
